FILE: src/ccp_pkg.sv
// Shared types and constants for the camera chunk header parser.
package ccp_pkg;

    // Default and widest supported datagram length
    localparam int MAX_PACKET_BYTES_DEF = 65535;
    // Width that holds any byte count up to the saturation value 65536
    localparam int CNT_EXT_W = 17;

    // Layout mode register codes
    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_LEGACY  = 2'd1;
    localparam logic [1:0] MODE_STAMPED = 2'd2;

    // Status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_BAD_MAGIC   = 4'd2;
    localparam logic [3:0] ST_STAMP_SHORT = 4'd3;
    localparam logic [3:0] ST_NSEC_RANGE  = 4'd4;
    localparam logic [3:0] ST_INDEX_RANGE = 4'd5;
    localparam logic [3:0] ST_SIZE_BAD    = 4'd6;
    localparam logic [3:0] ST_BAD_TAIL    = 4'd7;
    localparam logic [3:0] ST_TOO_LONG    = 4'd8;

    // Header limits
    localparam logic [31:0] MAX_INDEX    = 32'd10000;
    localparam logic [31:0] MAX_DECLARED = 32'd104857600;
    localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
    localparam logic [CNT_EXT_W-1:0] LEGACY_MIN  = 17'd13;
    localparam logic [CNT_EXT_W-1:0] STAMPED_MIN = 17'd21;
    localparam logic [4:0] STAMPED_OFFSET = 5'd19;
    localparam logic [4:0] LEGACY_OFFSET  = 5'd11;

    // Header byte window (positions 3..18)
    localparam logic [CNT_EXT_W-1:0] HDR_FIRST = 17'd3;
    localparam logic [CNT_EXT_W-1:0] HDR_LAST  = 17'd18;

    // Magic and tail characters
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_I = 8'h49;

    // One decoded chunk descriptor
    typedef struct packed {
        logic [3:0]  status;
        logic        layout_used;
        logic [31:0] seconds;
        logic [31:0] nanoseconds;
        logic [31:0] chunk_index;
        logic [31:0] size_decl;
        logic        tail_final;
        logic [4:0]  pay_start;
        logic [15:0] payload_length;
        logic [15:0] packet_length;
    } ccp_desc_t;

endpackage

FILE: src/ccp_decode.sv
// Descriptor decode: checks and field extraction at the final byte of a datagram.
module ccp_decode #(
    parameter int MAX_PACKET_BYTES = ccp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic [ccp_pkg::CNT_EXT_W-1:0] count,
    input  logic [15:0][7:0]              hdr,
    input  logic                          magic_ok,
    input  logic [7:0]                    prev_byte,
    input  logic [7:0]                    cur_byte,
    input  logic [1:0]                    layout_mode,
    output ccp_pkg::ccp_desc_t            desc
);
    import ccp_pkg::*;

    localparam logic [CNT_EXT_W-1:0] MAX_CNT = CNT_EXT_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_EXT_W-1:0] PLEN_MAX = 17'd65535;

    logic [31:0]          w0, w1, w2, w3;
    logic                 too_long, short_pkt, long_enough, auto_stamped;
    logic                 stamped;
    logic [3:0]           status;
    logic [31:0]          idx, decl;
    logic [4:0]           offset;
    logic [CNT_EXT_W-1:0] avail;
    logic                 tail_ok;

    // Little-endian header words
    assign w0 = hdr[3:0];
    assign w1 = hdr[7:4];
    assign w2 = hdr[11:8];
    assign w3 = hdr[15:12];

    assign too_long     = count > MAX_CNT;
    assign short_pkt    = count < LEGACY_MIN;
    assign long_enough  = count >= STAMPED_MIN;
    assign auto_stamped = long_enough && (w1 < NS_PER_SEC) && (w2 < MAX_INDEX)
                          && (w3 < MAX_DECLARED);
    assign tail_ok      = ((prev_byte == CH_A) || (prev_byte == CH_E)) && (cur_byte == CH_I);

    // Layout choice
    always_comb begin
        case (layout_mode)
            MODE_LEGACY:  stamped = 1'b0;
            MODE_STAMPED: stamped = 1'b1;
            default:      stamped = auto_stamped;
        endcase
    end

    assign idx    = stamped ? w2 : w0;
    assign decl   = stamped ? w3 : w1;
    assign offset = stamped ? STAMPED_OFFSET : LEGACY_OFFSET;
    assign avail  = count - CNT_EXT_W'(offset) - 17'd2;

    // Checks in priority order
    always_comb begin
        if (too_long) begin
            status = ST_TOO_LONG;
        end else if (short_pkt) begin
            status = ST_SHORT;
        end else if (!magic_ok) begin
            status = ST_BAD_MAGIC;
        end else if (stamped && !long_enough) begin
            status = ST_STAMP_SHORT;
        end else if (stamped && (w1 >= NS_PER_SEC)) begin
            status = ST_NSEC_RANGE;
        end else if (idx >= MAX_INDEX) begin
            status = ST_INDEX_RANGE;
        end else if ((decl == 32'd0) || (decl >= MAX_DECLARED)) begin
            status = ST_SIZE_BAD;
        end else if (!tail_ok) begin
            status = ST_BAD_TAIL;
        end else begin
            status = ST_OK;
        end
    end

    // Assemble descriptor; error beats keep only status and length
    always_comb begin
        desc = '0;
        desc.status        = status;
        desc.packet_length = (count > PLEN_MAX) ? 16'hFFFF : count[15:0];
        if (status == ST_OK) begin
            desc.layout_used    = stamped;
            desc.seconds        = stamped ? w0 : 32'd0;
            desc.nanoseconds    = stamped ? w1 : 32'd0;
            desc.chunk_index    = idx;
            desc.size_decl      = decl;
            desc.tail_final     = (prev_byte == CH_E);
            desc.pay_start      = offset;
            desc.payload_length = (decl <= 32'(avail)) ? decl[15:0] : avail[15:0];
        end
    end

endmodule

FILE: src/camera_chunk_header_parser.sv
// Top level of the camera chunk header parser: byte intake, header capture, output register.
// The parser takes one datagram byte per beat on the s_ channel and, on the beat flagged
// s_last_byte, loads one chunk descriptor into the output register on the m_ channel. It
// accepts a byte every cycle; a byte is held off only while a descriptor sits in the output
// register and m_ready is low. Bytes 3..18 are captured as they pass, the "MOR" magic is
// checked on bytes 0..2, and all checks run combinationally on the final byte. Datagrams
// longer than MAX_PACKET_BYTES report too_long. layout_mode selects auto-detect (0 or 3),
// legacy (1) or timestamped (2); write it only while the parser is idle (not enforced).
module camera_chunk_header_parser #(
    parameter int MAX_PACKET_BYTES = ccp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // descriptor output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_layout_used,
    output logic [31:0] m_seconds,
    output logic [31:0] m_nanoseconds,
    output logic [31:0] m_chunk_index,
    output logic [31:0] m_declared_size,
    output logic        m_is_final,
    output logic [4:0]  m_payload_offset,
    output logic [15:0] m_payload_length,
    output logic [15:0] m_packet_length
);
    import ccp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_PACKET_BYTES + 1);

    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             magic_reg, magic_next;
    logic [7:0]       prev_reg;
    logic [15:0][7:0] hdr_reg;
    logic             m_valid_reg;
    ccp_desc_t        desc_reg, desc_next;

    logic                 accept;
    logic [CNT_EXT_W-1:0] pos_ext, count_ext;
    logic [CNT_EXT_W-1:0] hdr_off;
    logic                 hdr_we;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Position of this byte and saturating count including it
    assign pos_ext    = CNT_EXT_W'(count_reg);
    assign count_next = (count_reg < LIMIT) ? count_reg + CNT_W'(1) : LIMIT;
    assign count_ext  = CNT_EXT_W'(count_next);
    assign hdr_off    = pos_ext - HDR_FIRST;
    assign hdr_we     = (pos_ext >= HDR_FIRST) && (pos_ext <= HDR_LAST);

    // Magic check on the first three bytes
    always_comb begin
        magic_next = magic_reg;
        if (pos_ext == 17'd0 && s_data_byte != CH_M) magic_next = 1'b0;
        if (pos_ext == 17'd1 && s_data_byte != CH_O) magic_next = 1'b0;
        if (pos_ext == 17'd2 && s_data_byte != CH_R) magic_next = 1'b0;
    end

    ccp_decode #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_decode (
        .count      (count_ext),
        .hdr        (hdr_reg),
        .magic_ok   (magic_next),
        .prev_byte  (prev_reg),
        .cur_byte   (s_data_byte),
        .layout_mode(mode_reg),
        .desc       (desc_next)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_AUTO;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Per-datagram control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            magic_reg <= 1'b1;
            prev_reg  <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                count_reg <= '0;
                magic_reg <= 1'b1;
                prev_reg  <= '0;
            end else begin
                count_reg <= count_next;
                magic_reg <= magic_next;
                prev_reg  <= s_data_byte;
            end
        end
    end

    // Header byte capture
    always_ff @(posedge aclk) begin
        if (accept && hdr_we) begin
            hdr_reg[hdr_off[3:0]] <= s_data_byte;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            desc_reg <= desc_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = desc_reg.status;
    assign m_layout_used    = desc_reg.layout_used;
    assign m_seconds        = desc_reg.seconds;
    assign m_nanoseconds    = desc_reg.nanoseconds;
    assign m_chunk_index    = desc_reg.chunk_index;
    assign m_declared_size  = desc_reg.size_decl;
    assign m_is_final       = desc_reg.tail_final;
    assign m_payload_offset = desc_reg.pay_start;
    assign m_payload_length = desc_reg.payload_length;
    assign m_packet_length  = desc_reg.packet_length;

endmodule
